[hdl/dfa_acceptor_engine_defines.svh]
// Assertion macros used by the checker file.
`ifndef DFA_ACCEPTOR_ENGINE_DEFINES_SVH
`define DFA_ACCEPTOR_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DFA_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dfa_pkg.sv]
`default_nettype none

package dfa_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_SYMBOLS = 32;

    localparam int STATE_W  = 6;
    localparam int SYM_W    = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    localparam int STATE_AW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int SYM_AW      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CNT_W       = $clog2(NUM_SYMBOLS + 1);
    localparam int TRANS_AW    = STATE_AW + SYM_AW;
    localparam int TRANS_DEPTH = 1 << TRANS_AW;

    typedef enum logic [OP_W-1:0] {
        OP_STEP       = 3'd0,
        OP_ADD_SYMBOL = 3'd1,
        OP_SET_TRANS  = 3'd2,
        OP_SET_FINAL  = 3'd3,
        OP_RESTART    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_NOTRANS = 3'd2,
        ST_NOCUR   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next;
    } trans_entry_t;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [TRANS_AW-1:0] addr;
        trans_entry_t        wdata;
    } trans_req_t;

    typedef struct packed {
        logic              hit;
        logic [SYM_AW-1:0] idx;
        logic              full;
    } alpha_look_t;

    function automatic logic state_in_range(input logic [STATE_W-1:0] s);
        return (int'(s) < NUM_STATES);
    endfunction

endpackage

`default_nettype wire

[hdl/dfa_alpha.sv]
`default_nettype none

// Alphabet store: append-only byte list with first-match lookup.
module dfa_alpha import dfa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [SYM_W-1:0] wr_byte,
    input  wire logic [SYM_W-1:0] look_byte,
    output alpha_look_t           look
);

    logic [SYM_W-1:0]       store_reg [NUM_SYMBOLS];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [NUM_SYMBOLS-1:0] match;
    logic [NUM_SYMBOLS-1:0] first;
    logic [SYM_AW-1:0]      idx;

    // caller only writes when not full
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[count_reg[SYM_AW-1:0]] <= wr_byte;
        end
    end

    assign count_next = wr_en ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // lowest matching index wins: isolate the lowest set bit, then OR-encode
    always_comb
    begin
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (store_reg[i] == look_byte);
        end
        first = match & (~match + NUM_SYMBOLS'(1));
        idx   = '0;
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            if (first[i])
            begin
                idx = idx | SYM_AW'(i);
            end
        end
    end

    assign look.hit  = |match;
    assign look.idx  = idx;
    assign look.full = (count_reg >= CNT_W'(NUM_SYMBOLS));

endmodule

`default_nettype wire

[hdl/dfa_trans_ram.sv]
`default_nettype none

// Transition memory {valid, next} with a registered read.
// Swept to zero after reset, one entry per cycle; busy while sweeping.
module dfa_trans_ram import dfa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire trans_req_t req,
    output trans_entry_t rd_data,
    output logic        busy
);

    trans_entry_t        mem [TRANS_DEPTH];
    trans_entry_t        rd_data_reg;
    logic [TRANS_AW-1:0] clr_addr_reg;
    logic [TRANS_AW-1:0] clr_addr_next;
    logic                busy_reg;
    logic                busy_next;

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.en && req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.en && !req.we)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + TRANS_AW'(1);
            if (clr_addr_reg == TRANS_AW'(TRANS_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

[hdl/dfa_acceptor_engine.sv]
// Programmable table-driven DFA acceptor. Each input transaction is one
// command (op): step on a byte, append a byte to the alphabet, write a
// transition, mark or clear a final state, or restart at start_state. Every
// command returns exactly one result transaction with a status code, the
// current state, whether it is valid, and whether it is accepting. Byte to
// alphabet index uses first match over the alphabet list; the transition
// table (64 states x 32 symbols) sits in a synchronous RAM with a valid bit
// per entry. Timing: a command is accepted, the next cycle does the RAM
// access, the cycle after forms the result and may accept the next command,
// so a new command waits for the result cycle of the one before, as the RAM
// read feeds the current-state register. A held result (out_stall) holds the
// engine in its result cycle. After reset the transition RAM is swept clear
// with in_stall high; start_state writes are taken at any time, but should
// only be issued with no command in flight.
`default_nettype none

module dfa_acceptor_engine import dfa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // start_state register
    input  wire logic                cfg_we,
    input  wire logic [STATE_W-1:0]  cfg_wdata,
    // command channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [SYM_W-1:0]    symbol,
    input  wire logic [STATE_W-1:0]  state_sel,
    input  wire logic [STATE_W-1:0]  target_state,
    input  wire logic                final_flag,
    // result channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [STATE_W-1:0]       current_state,
    output logic                     current_valid,
    output logic                     accepted
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_FINISH = 3'b100
    } fsm_t;

    fsm_t state_reg, state_next;

    // command held from acceptance to result
    op_t               d_op_reg;
    logic [SYM_W-1:0]  d_sym_reg;
    logic [STATE_W-1:0] d_sel_reg;
    logic [STATE_W-1:0] d_tgt_reg;
    logic              d_flag_reg;
    alpha_look_t       d_look_reg;

    logic [STATE_W-1:0] start_reg;
    logic [STATE_W-1:0] present_reg, present_next;
    logic               pval_reg, pval_next;
    logic [NUM_STATES-1:0] final_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATE_W-1:0]  cur_state_reg;
    logic                cur_valid_reg;
    logic                accepted_reg;

    alpha_look_t  look;
    trans_req_t   ram_req;
    trans_entry_t ram_rd;
    logic         ram_busy;

    logic    accept;
    logic    can_load;
    logic    fin_fire;
    logic    exec_cyc;
    logic    present_ok;
    logic    sel_ok;
    logic    tgt_ok;
    logic    alpha_wr;
    status_t fin_status;
    logic    res_valid;

    //--------------------------------------------------------------------
    // handshake and sequencing
    //--------------------------------------------------------------------
    assign can_load = !out_valid_reg || !out_stall;
    assign in_stall = ram_busy ||
                      !((state_reg == S_IDLE) || ((state_reg == S_FINISH) && can_load));
    assign accept   = in_valid && !in_stall;
    assign exec_cyc = (state_reg == S_EXEC);
    assign fin_fire = (state_reg == S_FINISH) && can_load;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
                else if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // lookup happens on the acceptance cycle; alphabet writes land in EXEC,
    // before the next command's lookup
    dfa_alpha u_alpha
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (alpha_wr),
        .wr_byte   (d_sym_reg),
        .look_byte (symbol),
        .look      (look)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_op_reg   <= op_t'(op);
            d_sym_reg  <= symbol;
            d_sel_reg  <= state_sel;
            d_tgt_reg  <= target_state;
            d_flag_reg <= final_flag;
            d_look_reg <= look;
        end
    end

    assign present_ok = pval_reg && state_in_range(present_reg);
    assign sel_ok     = state_in_range(d_sel_reg);
    assign tgt_ok     = state_in_range(d_tgt_reg);

    //--------------------------------------------------------------------
    // EXEC: RAM access, alphabet append, final mark
    //--------------------------------------------------------------------
    always_comb
    begin
        ram_req  = '0;
        alpha_wr = 1'b0;
        if (exec_cyc)
        begin
            case (d_op_reg)
                OP_STEP:
                begin
                    ram_req.en   = present_ok && d_look_reg.hit;
                    ram_req.addr = {STATE_AW'(present_reg), d_look_reg.idx};
                end
                OP_ADD_SYMBOL:
                begin
                    alpha_wr = !d_look_reg.full;
                end
                OP_SET_TRANS:
                begin
                    ram_req.en         = d_look_reg.hit && sel_ok && tgt_ok;
                    ram_req.we         = 1'b1;
                    ram_req.addr       = {STATE_AW'(d_sel_reg), d_look_reg.idx};
                    ram_req.wdata.valid = 1'b1;
                    ram_req.wdata.next  = d_tgt_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    dfa_trans_ram u_trans_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd),
        .busy    (ram_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_reg <= '0;
        end
        else if (exec_cyc && (d_op_reg == OP_SET_FINAL) && sel_ok)
        begin
            final_reg[STATE_AW'(d_sel_reg)] <= d_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            start_reg <= cfg_wdata;
        end
    end

    //--------------------------------------------------------------------
    // FINISH: status, state update, result
    //--------------------------------------------------------------------
    always_comb
    begin
        fin_status   = ST_OK;
        present_next = present_reg;
        pval_next    = pval_reg;
        case (d_op_reg)
            OP_STEP:
            begin
                if (!present_ok)
                begin
                    fin_status = ST_NOCUR;
                end
                else if (!d_look_reg.hit)
                begin
                    fin_status = ST_UNKNOWN;
                end
                else if (!ram_rd.valid)
                begin
                    fin_status = ST_NOTRANS;
                end
                else
                begin
                    present_next = ram_rd.next;
                end
            end
            OP_ADD_SYMBOL:
            begin
                if (d_look_reg.full)
                begin
                    fin_status = ST_FULL;
                end
            end
            OP_SET_TRANS:
            begin
                if (!d_look_reg.hit)
                begin
                    fin_status = ST_UNKNOWN;
                end
                else if (!sel_ok || !tgt_ok)
                begin
                    fin_status = ST_NOTRANS;
                end
            end
            OP_SET_FINAL:
            begin
                if (!sel_ok)
                begin
                    fin_status = ST_NOTRANS;
                end
            end
            OP_RESTART:
            begin
                if (state_in_range(start_reg))
                begin
                    present_next = start_reg;
                    pval_next    = 1'b1;
                end
                else
                begin
                    pval_next  = 1'b0;
                    fin_status = ST_NOCUR;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = pval_next && state_in_range(present_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            pval_reg    <= 1'b0;
        end
        else if (fin_fire)
        begin
            present_reg <= present_next;
            pval_reg    <= pval_next;
        end
    end

    // output register: refilled in the same cycle the old result drains
    assign out_valid_next = fin_fire ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            status_reg    <= fin_status;
            cur_state_reg <= res_valid ? present_next : '0;
            cur_valid_reg <= res_valid;
            accepted_reg  <= res_valid && final_reg[STATE_AW'(present_next)];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign current_state = cur_state_reg;
    assign current_valid = cur_valid_reg;
    assign accepted      = accepted_reg;

endmodule

`default_nettype wire

[hdl/dfa_chk.sv]
`default_nettype none
`include "dfa_acceptor_engine_defines.svh"

// Port-level checks for the acceptor engine.
module dfa_chk import dfa_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cfg_we,
    input wire logic [STATE_W-1:0]  cfg_wdata,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic [OP_W-1:0]     op,
    input wire logic [SYM_W-1:0]    symbol,
    input wire logic [STATE_W-1:0]  state_sel,
    input wire logic [STATE_W-1:0]  target_state,
    input wire logic                final_flag,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [STATE_W-1:0]  current_state,
    input wire logic                current_valid,
    input wire logic                accepted
);

    // after an accepted command in_stall goes high, so commands are never taken back to back
    `DFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted back to back")

    `DFA_ASSERT(a_invalid_state_zero, out_valid && !current_valid, current_state == '0, "state not zero")

    `DFA_ASSERT(a_accept_needs_state, out_valid && accepted, current_valid, "accepted without state")

    `DFA_ASSERT(a_nocur_is_invalid, out_valid && (status == ST_NOCUR), !current_valid, "nocur but valid")

    `DFA_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(status) && $stable(current_state), "result changed")

endmodule

bind dfa_acceptor_engine dfa_chk u_dfa_chk (.*);

`default_nettype wire
